/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the divisor-pair block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising edge out of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen on a rising edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* src/tdp_pkg.sv */
// Package for the trial-division divisor-pair block: widths, queue size,
// and the structs passed between front, queue, back and divider. No deps.
package tdp_pkg;

    // Bits of the input number that take part in the search (4..16).
    localparam int NUMBER_WIDTH = 16;

    // Port field widths, fixed by the interface.
    localparam int IN_W   = 16;
    localparam int DIV_W  = 8;
    localparam int COF_W  = 15;

    // Candidate reaches 2**ceil(NUMBER_WIDTH/2), one more bit than the root.
    localparam int CAND_W = (NUMBER_WIDTH + 1) / 2 + 1;
    localparam int SQ_W   = 2 * CAND_W;

    // Bit-serial divider step counter.
    localparam int DIV_CNT_W = $clog2(NUMBER_WIDTH + 1);

    // Queue between front and back; depth is a power of two.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One classified number on its way to the back part.
    typedef struct packed {
        logic [NUMBER_WIDTH-1:0] num;
        logic                    trivial;   // 0 or 1: no search, not prime
    } item_t;

    // Divider request and response.
    typedef struct packed {
        logic                    start;
        logic [NUMBER_WIDTH-1:0] dividend;
        logic [CAND_W-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic                    rem_zero;
        logic [NUMBER_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

/* src/tdp_if.sv */
// Valid/ready channel interfaces for the divisor-pair block.
// Depends on tdp_pkg for field widths.
interface tdp_in_if import tdp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface tdp_out_if import tdp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIV_W-1:0] small_divisor;
    logic [COF_W-1:0] cofactor;
    logic             is_square_root;
    logic             is_prime;
    logic             last;

    modport source (output valid, output small_divisor, output cofactor,
                    output is_square_root, output is_prime, output last,
                    input ready);
    modport sink   (input valid, input small_divisor, input cofactor,
                    input is_square_root, input is_prime, input last,
                    output ready);
endinterface

/* src/tdp_div.sv */
// Bit-serial restoring divider: number by candidate, one quotient bit per cycle.
// Depends on tdp_pkg.
module tdp_div import tdp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic                    done_reg;
    logic [CAND_W-1:0]       rem_reg;
    logic [NUMBER_WIDTH-1:0] quo_reg;
    logic [CAND_W-1:0]       dvs_reg;

    logic [CAND_W:0] shifted;
    logic [CAND_W:0] diff;
    logic            fits;

    // One restoring step
    assign shifted = {rem_reg, quo_reg[NUMBER_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= DIV_CNT_W'(NUMBER_WIDTH);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[CAND_W-1:0] : shifted[CAND_W-1:0];
            quo_reg <= {quo_reg[NUMBER_WIDTH-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_zero = (rem_reg == '0);
    assign rsp.quotient = quo_reg;

endmodule

/* src/tdp_fifo.sv */
// Short queue of classified numbers between front and back parts.
// Depends on tdp_pkg.
module tdp_fifo import tdp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t push_item,
    input  logic  push_valid,
    output logic  push_ready,
    output item_t pop_item,
    output logic  pop_valid,
    input  logic  pop_ready
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/tdp_front.sv */
// Front part: takes input beats, trims to the working width, flags 0 and 1.
// Depends on tdp_pkg and tdp_in_if.
module tdp_front import tdp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tdp_in_if.sink    din,
    output item_t     item,
    output logic      item_valid,
    input  logic      item_ready
);

    logic                    vld_reg;
    logic [NUMBER_WIDTH-1:0] num_reg;
    logic                    trivial_reg;
    logic [NUMBER_WIDTH-1:0] num_trim;
    logic                    take;

    assign num_trim  = din.number[NUMBER_WIDTH-1:0];
    assign din.ready = !vld_reg || item_ready;
    assign take      = din.valid && din.ready;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            vld_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    // Classify: 0 and 1 skip the search
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            num_reg     <= num_trim;
            trivial_reg <= (num_trim < NUMBER_WIDTH'(2));
        end
    end

    assign item.num     = num_reg;
    assign item.trivial = trivial_reg;
    assign item_valid   = vld_reg;

endmodule

/* src/tdp_back.sv */
// Back part: trial-division sequencer, pending-result hold and output register.
// Depends on tdp_pkg, tdp_div and tdp_out_if.
module tdp_back import tdp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  item_t     item,
    input  logic      item_valid,
    output logic      item_ready,
    tdp_out_if.source dout
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_TEST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_LAST = 3'd5;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [2:0]              state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] num_reg, num_next;
    logic                    prime_ok_reg, prime_ok_next;
    logic [CAND_W-1:0]       cand_reg, cand_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [CAND_W-1:0]       pend_div_reg, pend_div_next;
    logic [NUMBER_WIDTH-1:0] pend_cof_reg, pend_cof_next;
    logic                    pend_sq_reg, pend_sq_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DIV_W-1:0]        out_div_reg, out_div_next;
    logic [COF_W-1:0]        out_cof_reg, out_cof_next;
    logic                    out_sq_reg, out_sq_next;
    logic                    out_prime_reg, out_prime_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_load;
    logic                    out_free;

    tdp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !out_valid_reg || dout.ready;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        num_next        = num_reg;
        prime_ok_next   = prime_ok_reg;
        cand_next       = cand_reg;
        sq_next         = sq_reg;
        pend_valid_next = pend_valid_reg;
        pend_div_next   = pend_div_reg;
        pend_cof_next   = pend_cof_reg;
        pend_sq_next    = pend_sq_reg;
        out_load        = 1'b0;
        out_div_next    = out_div_reg;
        out_cof_next    = out_cof_reg;
        out_sq_next     = out_sq_reg;
        out_prime_next  = out_prime_reg;
        out_last_next   = out_last_reg;
        item_ready      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = num_reg;
        div_req.divisor  = cand_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    num_next        = item.num;
                    prime_ok_next   = !item.trivial;
                    cand_next       = CAND_W'(2);
                    pend_valid_next = 1'b0;
                    state_next      = item.trivial ? ST_LAST : ST_SQ;
                end
            end
            ST_SQ:
            begin
                sq_next    = SQ_W'(cand_reg) * SQ_W'(cand_reg);
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (sq_reg > SQ_W'(num_reg))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem_zero)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cand_next  = cand_reg + 1'b1;
                        state_next = ST_SQ;
                    end
                end
            end
            ST_EMIT:
            begin
                // Older pair leaves only when a newer one proves it is not last
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load       = 1'b1;
                        out_div_next   = DIV_W'(pend_div_reg);
                        out_cof_next   = COF_W'(pend_cof_reg);
                        out_sq_next    = pend_sq_reg;
                        out_prime_next = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_div_next   = cand_reg;
                    pend_cof_next   = div_rsp.quotient;
                    pend_sq_next    = (sq_reg == SQ_W'(num_reg));
                    cand_next       = cand_reg + 1'b1;
                    state_next      = ST_SQ;
                end
            end
            ST_LAST:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_div_next   = DIV_W'(pend_div_reg);
                        out_cof_next   = COF_W'(pend_cof_reg);
                        out_sq_next    = pend_sq_reg;
                        out_prime_next = 1'b0;
                    end
                    else
                    begin
                        out_div_next   = '0;
                        out_cof_next   = '0;
                        out_sq_next    = 1'b0;
                        out_prime_next = prime_ok_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cand_reg       <= CAND_W'(2);
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cand_reg       <= cand_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        prime_ok_reg  <= prime_ok_next;
        sq_reg        <= sq_next;
        pend_div_reg  <= pend_div_next;
        pend_cof_reg  <= pend_cof_next;
        pend_sq_reg   <= pend_sq_next;
        out_div_reg   <= out_div_next;
        out_cof_reg   <= out_cof_next;
        out_sq_reg    <= out_sq_next;
        out_prime_reg <= out_prime_next;
        out_last_reg  <= out_last_next;
    end

    assign dout.valid          = out_valid_reg;
    assign dout.small_divisor  = out_div_reg;
    assign dout.cofactor       = out_cof_reg;
    assign dout.is_square_root = out_sq_reg;
    assign dout.is_prime       = out_prime_reg;
    assign dout.last           = out_last_reg;

endmodule

/* src/trial_division_divisor_pairs_top.sv */
// Trial-division divisor pairs. Each input beat carries a number; the block
// returns one beat per divisor d >= 2 with d*d <= number (d, number/d, and
// a flag when d is the square root), or a single beat flagged prime when
// there is none; 0 and 1 give one beat with every field clear but last. The
// final beat of each number has last set. For each candidate divisor the back
// part squares it, compares the square with the number and runs the
// bit-serial divide to its done pulse, with an extra emit step when the
// candidate divides; it finishes one number before it takes another. The
// divider works one quotient bit per cycle. A two-entry queue lets the front
// keep taking numbers while the back works.
// Holds the top level; depends on tdp_pkg, tdp_if, tdp_front, tdp_fifo, tdp_back.
`include "assert_macros.svh"

module trial_division_divisor_pairs_top import tdp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tdp_in_if.sink    din,
    tdp_out_if.source dout
);

    item_t front_item;
    logic  front_valid;
    logic  front_ready;
    item_t queue_item;
    logic  queue_valid;
    logic  queue_ready;

    tdp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    tdp_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (queue_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    tdp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .dout       (dout)
    );

    // Result checks
    `ASSERT_AT(a_prime_alone, clk, rst_n,
        dout.valid && dout.is_prime |-> dout.last && dout.small_divisor == '0
        && dout.cofactor == '0, "prime beat must be a lone, empty last beat")
    `ASSERT_AT(a_root_last, clk, rst_n,
        dout.valid && dout.is_square_root |-> dout.last
        && COF_W'(dout.small_divisor) == dout.cofactor,
        "square-root beat must be last with equal divisor and cofactor")
    `ASSERT_NEVER(a_pair_order, clk, rst_n,
        dout.valid && dout.small_divisor != '0
        && (dout.is_prime || COF_W'(dout.small_divisor) > dout.cofactor),
        "divisor pair out of order or flagged prime")

endmodule
